// ===== hdl/dla_pkg.sv =====
// Shared types and constants for the drive letter allocator.
`default_nettype none
package dla_pkg;
	localparam int LetterW = 5;
	localparam int MaskW = 26;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_NONE = 2'd1,
		ST_SAVED = 2'd2,
		ST_DISABLED = 2'd3
	} status_t;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_SAVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_LOW = 2'd0,
		REG_HIGH = 2'd1,
		REG_FORBID = 2'd2,
		REG_MAXHIST = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DONE
	} fsm_state_t;

	// unit key as stored in one history entry
	typedef struct packed {
		logic [15:0] vendor;
		logic [15:0] product;
		logic [15:0] release_no;
		logic [7:0]  config_no;
		logic [7:0]  iface;
		logic [63:0] serial;
		logic [7:0]  otg;
	} key_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dla_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_full;
	} dla_stat_t;
endpackage
`default_nettype wire

// ===== hdl/drive_letter_allocator_with_history.sv =====
// Top level of the drive letter allocator with mount history.
// After a transaction is accepted, the history is walked one entry per cycle
// for the key match and letter scan; then the letter is chosen, the history
// updated and the result register loaded. A new transaction is taken only in
// the idle state, after the last one is committed; a result held by the
// receiver stalls the next commit. One item is in work at a time; the result
// register lets the next item be accepted and scanned while a result waits.
// Configuration writes are always taken and should arrive only while idle.
`default_nettype none
module drive_letter_allocator_with_history
	import dla_pkg::*;
#(
	parameter int HISTORY_DEPTH = 8,
	parameter int LETTER_COUNT = 26
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// vendor_id, product_id, device_release, config_number, interface_number,
	// serial_key, otg_info, letters_in_use, record_letter, zero pad
	input  wire [167:0] s_tdata,
	input  wire [0:0]   s_tuser,  // opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,  // granted_letter, history_count, zero pad
	output logic [1:0]  m_tuser,  // status
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [1:0]   cfg_index,
	input  wire [25:0]  cfg_data
);
	dla_cmd_t cmd;
	dla_stat_t stat;
	key_t in_key;
	logic [LetterW-1:0] out_letter;
	logic [3:0] out_count;

	assign cfg_ready = 1'b1;
	assign in_key = '{vendor: s_tdata[15:0], product: s_tdata[31:16],
		release_no: s_tdata[47:32], config_no: s_tdata[55:48],
		iface: s_tdata[63:56], serial: s_tdata[127:64], otg: s_tdata[135:128]};
	assign m_tdata = {7'd0, out_count, out_letter};

	dla_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_ready(m_tready), .stat(stat), .cmd(cmd)
	);

	dla_dp #(.HISTORY_DEPTH(HISTORY_DEPTH), .LETTER_COUNT(LETTER_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.cmd(cmd), .stat(stat),
		.in_op(s_tuser[0]), .in_key(in_key), .in_use(s_tdata[161:136]),
		.in_letter(s_tdata[166:162]),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_letter(out_letter),
		.out_status(m_tuser), .out_count(out_count)
	);
endmodule
`default_nettype wire

// ===== hdl/dla_ctrl.sv =====
// Sequencer: accept, walk the history, commit the result.
`default_nettype none
module dla_ctrl
	import dla_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire            out_ready,
	input  wire dla_stat_t stat,
	output dla_cmd_t       cmd
);
	fsm_state_t state_q, state_next;
	logic can_commit;

	assign can_commit = !stat.out_full || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			FSM_IDLE: if (in_valid) state_next = FSM_SCAN;
			FSM_SCAN: if (stat.scan_last) state_next = FSM_DONE;
			FSM_DONE: if (can_commit) state_next = FSM_IDLE;
			default: state_next = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			FSM_SCAN: cmd.scan = 1'b1;
			FSM_DONE: cmd.commit = can_commit;
			default: ;
		endcase
	end

	a_commit_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == FSM_IDLE) else $error("commit did not return to idle");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN && stat.scan_last) |=> state_q == FSM_DONE)
		else $error("scan end missed");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("overlapping commands");
endmodule
`default_nettype wire

// ===== hdl/dla_dp.sv =====
// Datapath: config registers, history entries, scan and letter choice.
`default_nettype none
module dla_dp
	import dla_pkg::*;
#(
	parameter int HISTORY_DEPTH = 8,
	parameter int LETTER_COUNT = 26
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire [1:0]          cfg_idx,
	input  wire [MaskW-1:0]    cfg_wdata,
	input  wire dla_cmd_t      cmd,
	output dla_stat_t          stat,
	input  wire                in_op,
	input  wire key_t          in_key,
	input  wire [MaskW-1:0]    in_use,
	input  wire [LetterW-1:0]  in_letter,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [LetterW-1:0] out_letter,
	output logic [1:0]         out_status,
	output logic [3:0]         out_count
);
	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	logic [LetterW-1:0] low_q, high_q;
	logic [MaskW-1:0]   forbid_q;
	logic [3:0]         maxh_q;

	key_t               ent_key_q [HISTORY_DEPTH];
	logic [LetterW-1:0] ent_let_q [HISTORY_DEPTH];
	logic [CW-1:0]      used_q;

	logic               op_q;
	key_t               key_q;
	logic [MaskW-1:0]   use_q;
	logic [LetterW-1:0] rec_q;

	logic [IW-1:0]      idx_q;
	logic               mfound_q;
	logic [IW-1:0]      mpos_q;
	logic [LetterW-1:0] mlet_q;
	logic [31:0]        hmask_q;

	logic [LetterW-1:0] res_letter_q;
	logic [1:0]         res_status_q;
	logic [CW-1:0]      res_count_q;
	logic               res_valid_q;

	logic               idx_live;
	logic [31:0]        avail, fresh;
	logic [LetterW-1:0] first_avail, first_fresh;
	logic               do_save, remove;
	logic [IW-1:0]      rm_pos;
	logic [5:0]         limit;
	logic [CW-1:0]      slot;
	logic [LetterW-1:0] grant;
	status_t            st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= LetterW'(25);
			forbid_q <= '0;
			maxh_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_idx))
				REG_LOW: low_q <= cfg_wdata[LetterW-1:0];
				REG_HIGH: high_q <= cfg_wdata[LetterW-1:0];
				REG_FORBID: forbid_q <= cfg_wdata;
				REG_MAXHIST: maxh_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			key_q <= in_key;
			use_q <= in_use;
			rec_q <= in_letter;
		end
	end

	assign idx_live = CW'(idx_q) < used_q;
	assign stat.scan_last = (idx_q == IW'(HISTORY_DEPTH - 1));
	assign stat.out_full = res_valid_q;

	// one entry per cycle: first key match and set of letters named
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			mfound_q <= 1'b0;
			mpos_q <= '0;
			mlet_q <= '0;
			hmask_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
			mfound_q <= 1'b0;
			hmask_q <= '0;
		end else if (cmd.scan) begin
			if (!stat.scan_last) idx_q <= idx_q + 1'b1;
			if (idx_live) begin
				hmask_q[ent_let_q[idx_q]] <= 1'b1;
				if (!mfound_q && ent_key_q[idx_q] == key_q) begin
					mfound_q <= 1'b1;
					mpos_q <= idx_q;
					mlet_q <= ent_let_q[idx_q];
				end
			end
		end
	end

	// letters past the mask width have no forbid or in-use bit
	always_comb begin
		for (int l = 0; l < 32; l++) begin
			avail[l] = (l < LETTER_COUNT) &&
				(LetterW'(l) >= low_q) && (LetterW'(l) <= high_q) &&
				((l >= MaskW) || (!forbid_q[l % MaskW] && !use_q[l % MaskW]));
		end
		fresh = avail & ~hmask_q;
		first_avail = '0;
		first_fresh = '0;
		for (int l = 31; l >= 0; l--) begin
			if (avail[l]) first_avail = LetterW'(l);
			if (fresh[l]) first_fresh = LetterW'(l);
		end
	end

	always_comb begin
		limit = (6'(maxh_q) < 6'(HISTORY_DEPTH)) ? 6'(maxh_q) : 6'(HISTORY_DEPTH);
		do_save = (op_q == OP_SAVE) && (maxh_q != 4'd0);
		remove = mfound_q || (6'(used_q) >= limit);
		rm_pos = mfound_q ? mpos_q : '0;
		slot = remove ? used_q - 1'b1 : used_q;
		grant = '0;
		if (op_q == OP_SAVE) begin
			st = (maxh_q == 4'd0) ? ST_DISABLED : ST_SAVED;
		end else if (avail == '0) begin
			st = ST_NONE;
		end else begin
			st = ST_GRANTED;
			grant = (fresh != '0) ? first_fresh : first_avail;
			if (mfound_q && avail[mlet_q]) grant = mlet_q;
		end
	end

	// remove shifts later entries up; new record lands at the end
	for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_ent
		always_ff @(posedge clk) begin
			if (cmd.commit && do_save) begin
				if (CW'(k) == slot) begin
					ent_key_q[k] <= key_q;
					ent_let_q[k] <= rec_q;
				end else if (remove && IW'(k) >= rm_pos && k + 1 < HISTORY_DEPTH) begin
					ent_key_q[k] <= ent_key_q[(k + 1) % HISTORY_DEPTH];
					ent_let_q[k] <= ent_let_q[(k + 1) % HISTORY_DEPTH];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && do_save) used_q <= slot + 1'b1;
			if (cmd.commit) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_letter_q <= grant;
			res_status_q <= st;
			res_count_q <= do_save ? slot + 1'b1 : used_q;
		end
	end

	assign out_valid = res_valid_q;
	assign out_letter = res_letter_q;
	assign out_status = res_status_q;
	assign out_count = 4'(res_count_q);

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(HISTORY_DEPTH)) else $error("history count overflow");
	a_match_live: assert property (@(posedge clk) disable iff (!arst_n)
		mfound_q |-> CW'(mpos_q) < used_q) else $error("match beyond history");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out_ready) |-> !cmd.commit) else $error("result overwritten");
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the drive letter allocator: directed and random mounts.
module tb;
	import dla_pkg::*;

	typedef struct {
		opcode_t     op;
		key_t        key;
		logic [25:0] in_use;
		logic [4:0]  rec;
	} mount_req_t;

	typedef struct {
		logic [4:0] letter;
		status_t    status;
		logic [3:0] count;
	} grant_t;

	class grant_board;
		logic [4:0]  perm_lo;
		logic [4:0]  perm_hi;
		logic [25:0] forbid;
		logic [3:0]  max_hist;
		key_t        hkey [8];
		logic [4:0]  hletter [8];
		int          used;
		grant_t      pending [$];
		int          errors;

		function new();
			perm_lo = 5'd0;
			perm_hi = 5'd25;
			forbid = '0;
			max_hist = 4'd8;
			used = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [25:0] val);
			case (idx)
				REG_LOW: perm_lo = val[4:0];
				REG_HIGH: perm_hi = val[4:0];
				REG_FORBID: forbid = val;
				REG_MAXHIST: max_hist = val[3:0];
				default: ;
			endcase
		endfunction

		function bit usable(int l, logic [25:0] in_use);
			if (l >= 26 || l < perm_lo || l > perm_hi) return 0;
			return !forbid[l] && !in_use[l];
		endfunction

		function int find_key(key_t k);
			for (int i = 0; i < used; i++)
				if (hkey[i] == k) return i;
			return -1;
		endfunction

		function bit in_history(int l);
			for (int i = 0; i < used; i++)
				if (hletter[i] == l) return 1;
			return 0;
		endfunction

		function void drop(int pos);
			for (int i = pos; i + 1 < used; i++) begin
				hkey[i] = hkey[i + 1];
				hletter[i] = hletter[i + 1];
			end
			if (used > 0) used--;
		endfunction

		// predict the grant for one accepted transaction
		function void note_input(mount_req_t r);
			grant_t g;
			int     hit;
			int     lim;
			bit     any;
			hit = find_key(r.key);
			g.letter = 5'd0;
			any = 0;
			if (r.op == OP_REQUEST) begin
				for (int l = 0; l < 26; l++) begin
					if (!usable(l, r.in_use)) continue;
					if (!any) begin
						any = 1;
						g.letter = 5'(l);
					end
					if (!in_history(l)) begin
						g.letter = 5'(l);
						break;
					end
				end
				if (!any) begin
					g.letter = 5'd0;
					g.status = ST_NONE;
				end else begin
					if (hit >= 0 && usable(hletter[hit], r.in_use)) g.letter = hletter[hit];
					g.status = ST_GRANTED;
				end
			end else if (max_hist == 0) begin
				g.status = ST_DISABLED;
			end else begin
				lim = (max_hist < 8) ? max_hist : 8;
				if (hit >= 0) drop(hit);
				else if (used >= lim) drop(0);
				if (used >= 8) drop(0);
				hkey[used] = r.key;
				hletter[used] = r.rec;
				used++;
				g.status = ST_SAVED;
			end
			g.count = 4'(used);
			pending.push_back(g);
		endfunction

		task report(string what, int got, int want);
			$display("MISMATCH %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(logic [4:0] letter, logic [1:0] st, logic [3:0] cnt);
			grant_t g;
			if (pending.size() == 0) begin
				report("unexpected result, status", st, -1);
				return;
			end
			g = pending.pop_front();
			if (letter !== g.letter) report("granted_letter", letter, g.letter);
			if (st !== g.status) report("status", st, g.status);
			if (cnt !== g.count) report("history_count", cnt, g.count);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [25:0]  cfg_data;

	grant_board sb;
	key_t       key_pool [10];
	bit         rx_free;
	bit         hold_req;
	int         idle_cycles;

	drive_letter_allocator_with_history u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result side: random backpressure, long hold on request
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				stall = 300;
				m_tready <= 1'b0;
			end else if (rx_free) begin
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < 25) begin
				stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata[4:0], m_tuser, m_tdata[8:5]);
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
				!arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task write_reg(reg_index_t idx, logic [25:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task send(mount_req_t r, bit allow_gap);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= r.op;
		s_tdata <= {1'b0, r.rec, r.in_use, r.key.otg, r.key.serial, r.key.iface,
			r.key.config_no, r.key.release_no, r.key.product, r.key.vendor};
		do @(posedge clk); while (!s_tready);
		sb.note_input(r);
		if (allow_gap && $urandom_range(0, 99) < 30) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function key_t rand_key();
		key_t k;
		k.vendor = 16'($urandom);
		k.product = 16'($urandom);
		k.release_no = 16'($urandom);
		k.config_no = 8'($urandom);
		k.iface = 8'($urandom);
		k.serial = {$urandom, $urandom};
		k.otg = 8'($urandom);
		return k;
	endfunction

	function mount_req_t make_item();
		mount_req_t r;
		int         pick;
		r.op = ($urandom_range(0, 1) == 1) ? OP_SAVE : OP_REQUEST;
		r.key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 9)] : rand_key();
		pick = $urandom_range(0, 9);
		if (pick < 4) r.in_use = '0;
		else if (pick < 8) r.in_use = (26'd1 << $urandom_range(0, 25)) | (26'd1 << $urandom_range(0, 25));
		else if (pick < 9) r.in_use = 26'($urandom);
		else r.in_use = ~(26'd1 << $urandom_range(0, 25));
		r.rec = 5'($urandom_range(0, 25));
		return r;
	endfunction

	task random_run(int n);
		for (int i = 0; i < n; i++) send(make_item(), 1);
	endtask

	initial begin
		mount_req_t r;
		sb = new();
		rx_free = 0;
		hold_req = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOW;
		cfg_data = '0;
		for (int i = 0; i < 10; i++) key_pool[i] = rand_key();
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty history, save/recall, all letters busy, key extremes
		rx_free = 1;
		r = '{OP_REQUEST, key_pool[0], 26'd0, 5'd0};
		send(r, 0);
		r = '{OP_SAVE, key_pool[0], 26'd0, 5'd5};
		send(r, 0);
		r = '{OP_REQUEST, key_pool[0], 26'd0, 5'd0};
		send(r, 0);
		r = '{OP_REQUEST, key_pool[1], 26'd0, 5'd0};
		send(r, 0);
		r = '{OP_REQUEST, key_pool[0], 26'd1 << 5, 5'd0};
		send(r, 0);
		r = '{OP_REQUEST, key_pool[1], '1, 5'd31 & 5'd25};
		send(r, 0);
		r = '{OP_SAVE, key_pool[1], '1, 5'd25};
		send(r, 0);
		r = '{OP_SAVE, key_pool[0], 26'd0, 5'd7};
		send(r, 0);
		for (int i = 2; i < 10; i++) begin
			r = '{OP_SAVE, key_pool[i], 26'd0, 5'(i)};
			send(r, 0);
		end
		r = '{OP_REQUEST, key_pool[9], 26'h2AAAAAA, 5'd0};
		send(r, 0);
		r = '{OP_REQUEST, key_pool[2], 26'h1555555, 5'd0};
		send(r, 0);
		rx_free = 0;
		random_run(150);

		// long receiver hold while the sender keeps offering
		hold_req = 1;
		random_run(60);
		drain();

		write_reg(REG_LOW, 26'd3);
		write_reg(REG_HIGH, 26'd20);
		write_reg(REG_FORBID, 26'h0000F30);
		write_reg(REG_MAXHIST, 26'd4);
		random_run(150);
		drain();

		// shrink the limit below the current fill
		write_reg(REG_MAXHIST, 26'd1);
		random_run(120);
		drain();

		write_reg(REG_MAXHIST, 26'd0);
		write_reg(REG_LOW, 26'd25);
		write_reg(REG_HIGH, 26'd25);
		random_run(100);
		drain();

		// inverted range: nothing available
		write_reg(REG_LOW, 26'd20);
		write_reg(REG_HIGH, 26'd2);
		write_reg(REG_MAXHIST, 26'd15);
		random_run(100);
		drain();

		write_reg(REG_LOW, 26'd0);
		write_reg(REG_HIGH, 26'd25);
		write_reg(REG_FORBID, 26'h3FFFFFF);
		random_run(60);
		drain();

		write_reg(REG_FORBID, 26'h2AAAAAA);
		write_reg(REG_MAXHIST, 26'd8);
		rx_free = 1;
		random_run(150);
		rx_free = 0;
		// sender waits for every result before resuming
		drain();
		write_reg(REG_FORBID, 26'($urandom));
		write_reg(REG_MAXHIST, 26'd3);
		random_run(200);
		drain();
		write_reg(REG_FORBID, 26'd0);
		write_reg(REG_MAXHIST, 26'd8);
		random_run(140);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== drive_letter_allocator_with_history.f =====
hdl/dla_pkg.sv
hdl/dla_ctrl.sv
hdl/dla_dp.sv
hdl/drive_letter_allocator_with_history.sv
bench/tb.sv
